[rtl/bpc_pkg.sv]
package bpc_pkg;

  // Item operation codes.
  localparam logic OP_TEMP = 1'b0;
  localparam logic OP_PRES = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_AC1_AC2 = 3'd0;
  localparam logic [2:0] REG_AC3_AC4 = 3'd1;
  localparam logic [2:0] REG_AC5_AC6 = 3'd2;
  localparam logic [2:0] REG_B1_B2   = 3'd3;
  localparam logic [2:0] REG_MC_MD   = 3'd4;
  localparam logic [2:0] REG_OSS     = 3'd5;

  // Compensation constants.
  localparam logic signed [31:0] K_B6_OFS   = 32'sd4000;
  localparam logic signed [31:0] K_P_SQ     = 32'sd3038;
  localparam logic signed [31:0] K_P_LIN    = -32'sd7357;
  localparam logic signed [31:0] K_P_OFS    = 32'sd3791;
  localparam logic [31:0]        K_B7_SCALE = 32'd50000;
  localparam logic [31:0]        K_B4_OFS   = 32'd32768;
  localparam logic signed [31:0] K_ROUND8   = 32'sd8;

  // Serial multiplier request and response.
  typedef struct packed {
    logic        start;
    logic [31:0] a;   // signed operand
    logic [31:0] b;   // unsigned operand
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
  } mul_rsp_t;

  // Serial divider request and response.
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

endpackage

[rtl/bpc_mul.sv]
module bpc_mul (
  input  logic              clk,
  input  logic              rst,
  input  bpc_pkg::mul_req_t req,
  output bpc_pkg::mul_rsp_t rsp
);
  import bpc_pkg::*;

  logic [31:0] a_reg;
  logic [32:0] hi;
  logic [31:0] lo;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [33:0] sum;

  // One multiplier bit per cycle: add the signed operand, then shift right.
  assign sum = {hi[32], hi} + (lo[0] ? {{2{a_reg[31]}}, a_reg} : 34'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == 5'd31);
      if (req.start) begin
        a_reg <= req.a;
        hi    <= '0;
        lo    <= req.b;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        hi  <= sum[33:1];
        lo  <= {sum[0], lo[31:1]};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = {hi[31:0], lo};

endmodule

[rtl/bpc_div.sv]
module bpc_div (
  input  logic              clk,
  input  logic              rst,
  input  bpc_pkg::div_req_t req,
  output bpc_pkg::div_rsp_t rsp
);
  import bpc_pkg::*;

  logic [31:0] den_reg;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] trial;
  logic [32:0] diff;

  // Restoring division, one quotient bit per cycle.
  assign trial = {rem, quo[31]};
  assign diff  = trial - {1'b0, den_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == 5'd31);
      if (req.start) begin
        den_reg <= req.den;
        rem     <= '0;
        quo     <= req.num;
        cnt     <= '0;
        busy    <= 1'b1;
      end else if (busy) begin
        if (!diff[32]) begin
          rem <= diff[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

[rtl/barometer_temp_pressure_compensation.sv]
// Each beat runs as a chain of serial multiply and divide steps, each a launch, the serial
// iterations and a hand-off: one of each for temperature, ten multiplies and one divide
// for pressure. Only one beat is in flight at a time; the next beat is taken the cycle after
// its result is loaded, even while that result still waits.
// Reset (rst, synchronous) clears calibration, oversampling, the kept term and handshakes.
module barometer_temp_pressure_compensation (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               operation,
  input  logic [18:0]        raw_value,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] value,
  output logic               valid_res
);
  import bpc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_TMUL, ST_TDIV, ST_PM1, ST_PM2, ST_PM3, ST_PM4, ST_PM5,
    ST_PM6, ST_PM7, ST_PDIV, ST_PM8, ST_PM9, ST_PM10, ST_OUT
  } state_t;

  state_t state;
  logic   launched;

  logic [31:0] r_ac1_ac2, r_ac3_ac4, r_ac5_ac6, r_b1_b2, r_mc_md;
  logic [1:0]  oss;
  logic signed [31:0] temp_term;

  logic [18:0]        raw;
  logic signed [31:0] x1t;
  logic               neg;
  logic signed [31:0] s1, acc, b3, p;
  logic [31:0]        b4;
  logic               dbl;
  logic signed [31:0] fin_value;
  logic               fin_ok;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;

  bpc_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
  bpc_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // Calibration fields.
  logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [31:0]        ac4, ac5, ac6;
  logic signed [31:0] b6, lo, mc_sh, den_t, quo_s;
  logic signed [16:0] ut_diff;
  logic signed [31:0] x3_now, b3_now, x3_b4, t_fin, d_fin, b5_now;
  logic [31:0]        mag_num, mag_den;

  assign ac1 = {{16{r_ac1_ac2[31]}}, r_ac1_ac2[31:16]};
  assign ac2 = {{16{r_ac1_ac2[15]}}, r_ac1_ac2[15:0]};
  assign ac3 = {{16{r_ac3_ac4[31]}}, r_ac3_ac4[31:16]};
  assign ac4 = {16'd0, r_ac3_ac4[15:0]};
  assign ac5 = {16'd0, r_ac5_ac6[31:16]};
  assign ac6 = {16'd0, r_ac5_ac6[15:0]};
  assign b1  = {{16{r_b1_b2[31]}}, r_b1_b2[31:16]};
  assign b2  = {{16{r_b1_b2[15]}}, r_b1_b2[15:0]};
  assign mc  = {{16{r_mc_md[31]}}, r_mc_md[31:16]};
  assign md  = {{16{r_mc_md[15]}}, r_mc_md[15:0]};

  assign b6      = temp_term - K_B6_OFS;
  assign lo      = $signed(mrsp.prod[31:0]);
  assign ut_diff = $signed({1'b0, raw[15:0]}) - $signed({1'b0, ac6[15:0]});

  // Temperature divide operands and the signed quotient.
  assign mc_sh   = mc <<< 11;
  assign den_t   = $signed(mrsp.prod[46:15]) + md;
  assign mag_num = mc_sh[31] ? 32'(-mc_sh) : 32'(mc_sh);
  assign mag_den = den_t[31] ? 32'(-den_t) : 32'(den_t);
  assign quo_s   = neg ? -$signed(drsp.quo) : $signed(drsp.quo);
  assign b5_now  = x1t + quo_s;

  // Pressure intermediate sums.
  assign x3_now = acc + (lo >>> 11);
  assign b3_now = ((((ac1 <<< 2) + x3_now) << oss) + 32'sd2) >>> 2;
  assign x3_b4  = (acc + (lo >>> 16) + 32'sd2) >>> 2;
  assign t_fin  = acc + (lo >>> 16) + K_P_OFS;
  assign d_fin  = (t_fin + (t_fin[31] ? 32'sd15 : 32'sd0)) >>> 4;

  // Multiplier operand selection per step.
  always_comb begin
    mreq.a = '0;
    mreq.b = '0;
    case (state)
      ST_TMUL: begin
        mreq.a = {{15{ut_diff[16]}}, ut_diff};
        mreq.b = ac5;
      end
      ST_PM1: begin
        mreq.a = b6;
        mreq.b = b6;
      end
      ST_PM2: begin
        mreq.a = s1;
        mreq.b = b2;
      end
      ST_PM3: begin
        mreq.a = ac2;
        mreq.b = b6;
      end
      ST_PM4: begin
        mreq.a = ac3;
        mreq.b = b6;
      end
      ST_PM5: begin
        mreq.a = s1;
        mreq.b = b1;
      end
      ST_PM6: begin
        mreq.a = acc + K_B4_OFS;
        mreq.b = ac4;
      end
      ST_PM7: begin
        mreq.a = {13'd0, raw} - b3;
        mreq.b = K_B7_SCALE >> oss;
      end
      ST_PM8: begin
        mreq.a = p >>> 8;
        mreq.b = p >>> 8;
      end
      ST_PM9: begin
        mreq.a = acc;
        mreq.b = K_P_SQ;
      end
      ST_PM10: begin
        mreq.a = K_P_LIN;
        mreq.b = p;
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
    mreq.start = !launched && (state != ST_IDLE) && (state != ST_OUT) &&
                 (state != ST_TDIV) && (state != ST_PDIV);
  end

  // Divider operands are held in registers loaded before the divide step.
  logic [31:0] dnum, dden;
  assign dreq.start = !launched && ((state == ST_TDIV) || (state == ST_PDIV));
  assign dreq.num   = dnum;
  assign dreq.den   = dden;

  assign item_stall = (state != ST_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_ac1_ac2 <= '0;
      r_ac3_ac4 <= '0;
      r_ac5_ac6 <= '0;
      r_b1_b2   <= '0;
      r_mc_md   <= '0;
      oss       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AC1_AC2: r_ac1_ac2 <= cfg_data;
        REG_AC3_AC4: r_ac3_ac4 <= cfg_data;
        REG_AC5_AC6: r_ac5_ac6 <= cfg_data;
        REG_B1_B2:   r_b1_b2   <= cfg_data;
        REG_MC_MD:   r_mc_md   <= cfg_data;
        REG_OSS:     oss       <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Step sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      launched     <= 1'b0;
      temp_term    <= '0;
      result_valid <= 1'b0;
    end else begin
      // The output register fills from ST_OUT and empties on an accepted result beat.
      if (state == ST_OUT && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (mreq.start || dreq.start) begin
        launched <= 1'b1;
      end else if (mrsp.done || drsp.done) begin
        launched <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            raw   <= raw_value;
            state <= (operation == OP_TEMP) ? ST_TMUL : ST_PM1;
          end
        end
        ST_TMUL: begin
          if (mrsp.done) begin
            x1t <= $signed(mrsp.prod[46:15]);
            if (den_t == 32'sd0) begin
              fin_value <= '0;
              fin_ok    <= 1'b0;
              state     <= ST_OUT;
            end else begin
              dnum  <= mag_num;
              dden  <= mag_den;
              neg   <= mc_sh[31] ^ den_t[31];
              state <= ST_TDIV;
            end
          end
        end
        ST_TDIV: begin
          if (drsp.done) begin
            temp_term <= b5_now;
            fin_value <= (b5_now + K_ROUND8) >>> 4;
            fin_ok    <= 1'b1;
            state     <= ST_OUT;
          end
        end
        ST_PM1: begin
          if (mrsp.done) begin
            s1    <= lo >>> 12;
            state <= ST_PM2;
          end
        end
        ST_PM2: begin
          if (mrsp.done) begin
            acc   <= lo >>> 11;
            state <= ST_PM3;
          end
        end
        ST_PM3: begin
          if (mrsp.done) begin
            b3    <= b3_now;
            state <= ST_PM4;
          end
        end
        ST_PM4: begin
          if (mrsp.done) begin
            acc   <= lo >>> 13;
            state <= ST_PM5;
          end
        end
        ST_PM5: begin
          if (mrsp.done) begin
            acc   <= x3_b4;
            state <= ST_PM6;
          end
        end
        ST_PM6: begin
          if (mrsp.done) begin
            b4    <= mrsp.prod[31:0] >> 15;
            state <= ST_PM7;
          end
        end
        ST_PM7: begin
          if (mrsp.done) begin
            if (b4 == 32'd0) begin
              fin_value <= '0;
              fin_ok    <= 1'b0;
              state     <= ST_OUT;
            end else begin
              dnum  <= mrsp.prod[31] ? mrsp.prod[31:0] : {mrsp.prod[30:0], 1'b0};
              dden  <= b4;
              dbl   <= mrsp.prod[31];
              state <= ST_PDIV;
            end
          end
        end
        ST_PDIV: begin
          if (drsp.done) begin
            p     <= dbl ? $signed({drsp.quo[30:0], 1'b0}) : $signed(drsp.quo);
            state <= ST_PM8;
          end
        end
        ST_PM8: begin
          if (mrsp.done) begin
            acc   <= lo;
            state <= ST_PM9;
          end
        end
        ST_PM9: begin
          if (mrsp.done) begin
            acc   <= lo >>> 16;
            state <= ST_PM10;
          end
        end
        ST_PM10: begin
          if (mrsp.done) begin
            fin_value <= p + d_fin;
            fin_ok    <= 1'b1;
            state     <= ST_OUT;
          end
        end
        ST_OUT: begin
          // Load the output register once it is free or being drained.
          if (!result_valid || !result_stall) begin
            value     <= fin_value;
            valid_res <= fin_ok;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
